### rtl/core/kmpss_pkg.sv
// ----------------------------------------------------------------------------
// kmpss_pkg
// Shared types and constants of the substring search block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmpss_pkg;

  localparam int MAX_PATTERN_DEF     = 64;
  localparam int TEXT_INDEX_BITS_DEF = 16;
  localparam int CHAR_W              = 8;
  localparam int POS_W               = 16;

  // Input word kinds, carried on tuser.
  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } opcode_t;

  // Control handed from the top level to every cell of the row.
  typedef struct packed {
    logic load;     // shift a pattern byte into the row
    logic clear;    // drop the old pattern while loading the first byte of a new one
    logic restart;  // first text byte: forget partial matches
    logic scan;     // compare the text byte against the row
  } kmpss_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/kmpss_cell.sv
// ----------------------------------------------------------------------------
// kmpss_cell
// One pattern position: holds a pattern byte and a partial match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module kmpss_cell
  import kmpss_pkg::*;
#(
  parameter bit IS_TAIL = 1'b0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kmpss_ctrl_t       ctrl,
  input  wire logic [CHAR_W-1:0] char_in,
  input  wire logic [CHAR_W-1:0] right_byte,
  input  wire logic              right_valid,
  input  wire logic              left_valid,
  input  wire logic              left_hit,
  output logic [CHAR_W-1:0]      byte_r,
  output logic                   valid_r,
  output logic                   hit_r,
  output logic                   hit_nxt
);

  logic [CHAR_W-1:0] byte_nxt;
  logic              valid_nxt;
  logic              first;

  // The tail cell takes the new byte; the others take their right neighbor's.
  assign byte_nxt  = IS_TAIL ? char_in : right_byte;
  assign valid_nxt = IS_TAIL ? 1'b1 : (!ctrl.clear && right_valid);

  // The leftmost valid cell holds the first pattern byte and may start a match.
  assign first   = valid_r && !left_valid;
  assign hit_nxt = valid_r && (byte_r == char_in) &&
                   (first || (!ctrl.restart && left_hit));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      byte_r <= byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      if (ctrl.load) begin
        valid_r <= valid_nxt;
      end
      if (ctrl.scan) begin
        hit_r <= hit_nxt;
      end else if (ctrl.restart) begin
        hit_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/kmpss_row.sv
// ----------------------------------------------------------------------------
// kmpss_row
// Row of pattern cells; the pattern is kept right-aligned against the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module kmpss_row
  import kmpss_pkg::*;
#(
  parameter int N = MAX_PATTERN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kmpss_ctrl_t       ctrl,
  input  wire logic [CHAR_W-1:0] char_in,
  output logic                   hit,
  output logic [N-1:0]           valid_vec
);

  logic [CHAR_W-1:0] byte_q [N];
  logic [N-1:0]      hit_q;
  logic [N-1:0]      hit_d;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [CHAR_W-1:0] rb;
    logic              rv;
    logic              lv;
    logic              lh;

    if (i == N - 1) begin : g_tail
      assign rb = char_in;
      assign rv = 1'b1;
    end else begin : g_body
      assign rb = byte_q[i+1];
      assign rv = valid_vec[i+1];
    end

    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign lh = 1'b0;
    end else begin : g_link
      assign lv = valid_vec[i-1];
      assign lh = hit_q[i-1];
    end

    kmpss_cell #(
      .IS_TAIL (i == N - 1)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .char_in     (char_in),
      .right_byte  (rb),
      .right_valid (rv),
      .left_valid  (lv),
      .left_hit    (lh),
      .byte_r      (byte_q[i]),
      .valid_r     (valid_vec[i]),
      .hit_r       (hit_q[i]),
      .hit_nxt     (hit_d[i])
    );
  end

  // The last pattern byte always sits in the tail, so a full match shows there.
  assign hit = ctrl.scan && hit_d[N-1];

endmodule

`default_nettype wire

### rtl/core/kmp_substring_search.sv
// ----------------------------------------------------------------------------
// kmp_substring_search
// Streaming substring search: loads a pattern, then reports the first
// occurrence of it in a text at or after a given start index.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Contents
//  ---------+-----+-----------------------------------------------------------
//  in_*     | in  | tuser opcode (0 pattern, 1 text), tlast last byte,
//           |     | tdata {start_position, char_value}
//  out_*    | out | tuser found, tdata match_position; one word per completed text
//
// Every accepted input word is fully handled in the cycle it is accepted, so
// the block takes one word per clock unless the result side stalls; the row of
// compare cells advances all partial matches together, one cell per pattern position.
// A result sits in the output register until taken; input is held off only
// while that register is full and the result side stalls.
// Reset (rst_n low, synchronous) empties the pattern, ends any text and
// drops a pending result. No clearing pass is needed after reset.
// The pattern is stored right-aligned in the row, so a full match always
// appears at the tail cell and no select over the pattern length is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_substring_search
  import kmpss_pkg::*;
#(
  parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter int TEXT_INDEX_BITS = TEXT_INDEX_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] char_value, [23:8] start_position
  input  wire logic        in_tuser,   // [0] opcode
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] match_position
  output logic             out_tuser   // [0] found
);

  localparam int IW   = TEXT_INDEX_BITS;
  localparam int LW   = $clog2(MAX_PATTERN + 1);
  localparam int CMPW = (IW > POS_W) ? IW : POS_W;
  localparam int SW   = ((IW > LW) ? IW : LW) + 1;

  // Input word fields.
  opcode_t           op;
  logic [CHAR_W-1:0] char_value;
  logic [POS_W-1:0]  start_position;
  logic              in_acc;

  assign op             = opcode_t'(in_tuser);
  assign char_value     = in_tdata[CHAR_W-1:0];
  assign start_position = in_tdata[CHAR_W +: POS_W];
  assign in_acc         = in_tvalid && in_tready;

  // Control state.
  logic             pat_closed_r, pat_closed_nxt;
  logic             text_on_r, text_on_nxt;
  logic [LW-1:0]    plen_r, plen_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic             seen_r, seen_nxt;
  logic [IW-1:0]    first_at_r, first_at_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;

  // Working values.
  kmpss_ctrl_t      ctrl;
  logic             restart;
  logic [POS_W-1:0] start_eff;
  logic [IW-1:0]    cur;
  logic             seen_eff;
  logic [IW-1:0]    first_eff;
  logic             row_hit;
  logic [MAX_PATTERN-1:0] valid_vec;
  logic [LW-1:0]    len_base;
  logic [SW-1:0]    end_ext;
  logic [SW-1:0]    plen_ext;
  logic [IW-1:0]    hit_pos;
  logic [CMPW-1:0]  start_cmp;
  logic [CMPW-1:0]  cur_cmp;
  logic [CMPW-1:0]  next_cmp;
  logic [CMPW-1:0]  first_wide;
  logic [CMPW-1:0]  pos_wide;

  // Output register frees up either empty or being drained this cycle.
  assign in_tready = !out_valid_r || out_tready;

  always_comb begin
    restart   = (op == OP_TEXT) && !text_on_r;
    start_eff = restart ? start_position : start_r;
    cur       = restart ? '0 : idx_r;
    seen_eff  = restart ? 1'b0 : seen_r;
    first_eff = restart ? '0 : first_at_r;
    start_cmp = CMPW'(start_eff);
    cur_cmp   = CMPW'(cur);
    len_base  = pat_closed_r ? '0 : plen_r;

    ctrl.load    = in_acc && (op == OP_PATTERN) && (len_base < LW'(MAX_PATTERN));
    ctrl.clear   = pat_closed_r;
    ctrl.restart = in_acc && restart;
    ctrl.scan    = in_acc && (op == OP_TEXT) && (plen_r != '0) && !seen_eff &&
                   (cur_cmp >= start_cmp);

    // Match start index: text position after this byte minus the length.
    end_ext  = SW'(cur) + SW'(1);
    plen_ext = SW'(plen_r);
    hit_pos  = (end_ext >= plen_ext) ? IW'(end_ext - plen_ext) : '0;
  end

  kmpss_row #(
    .N (MAX_PATTERN)
  ) u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .char_in   (char_value),
    .hit       (row_hit),
    .valid_vec (valid_vec)
  );

  always_comb begin
    pat_closed_nxt = pat_closed_r;
    text_on_nxt    = text_on_r;
    plen_nxt       = plen_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    seen_nxt       = seen_r;
    first_at_nxt   = first_at_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_pos_nxt    = out_pos_r;
    next_cmp       = '0;
    first_wide     = '0;
    pos_wide       = '0;

    if (in_acc) begin
      if (op == OP_PATTERN) begin
        // A pattern word abandons any text in progress without a result.
        text_on_nxt    = 1'b0;
        plen_nxt       = ctrl.load ? (len_base + LW'(1)) : len_base;
        pat_closed_nxt = in_tlast;
      end else begin
        pat_closed_nxt = 1'b1;
        text_on_nxt    = !in_tlast;
        start_nxt      = start_eff;
        idx_nxt        = (cur != '1) ? (cur + IW'(1)) : cur;
        seen_nxt       = seen_eff || row_hit;
        first_at_nxt   = row_hit ? hit_pos : first_eff;

        if (in_tlast) begin
          next_cmp      = CMPW'(idx_nxt);
          first_wide    = CMPW'(first_at_nxt);
          out_valid_nxt = 1'b1;
          if (plen_r == '0) begin
            // Empty pattern matches at the start if the start lies in the text.
            out_found_nxt = start_cmp < next_cmp;
            out_pos_nxt   = out_found_nxt ? start_eff : '0;
          end else begin
            out_found_nxt = seen_nxt;
            pos_wide      = seen_nxt ? first_wide : '0;
            out_pos_nxt   = pos_wide[POS_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_closed_r <= 1'b0;
      text_on_r    <= 1'b0;
      plen_r       <= '0;
      idx_r        <= '0;
      start_r      <= '0;
      seen_r       <= 1'b0;
      first_at_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pat_closed_r <= pat_closed_nxt;
      text_on_r    <= text_on_nxt;
      plen_r       <= plen_nxt;
      idx_r        <= idx_nxt;
      start_r      <= start_nxt;
      seen_r       <= seen_nxt;
      first_at_r   <= first_at_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_pos_r;

  // The row's occupied cells always agree with the stored pattern length.
  a_len_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(plen_r))
    else $error("pattern length disagrees with occupied cells");

  // A miss always reports position zero.
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_pos_r == '0)
    else $error("not-found result carries a position");

  // A new result only follows the last text word of a text.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && in_tuser && in_tlast))
    else $error("result without a last text word");

  // Once a match is recorded the row is no longer scanned in that text.
  a_no_scan_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r && text_on_r && in_acc && (op == OP_TEXT) |-> !ctrl.scan)
    else $error("row scanned after a match");

endmodule

`default_nettype wire

### tb/kmp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmp_result_checker
// Watches both channels of the substring search block, works out the result
// of every text from the accepted input words and compares the results that
// come out, in order, field by field.
// ----------------------------------------------------------------------------

module kmp_result_checker
  import kmpss_pkg::*;
#(
  parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter int TEXT_INDEX_BITS = TEXT_INDEX_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] char_value, [23:8] start_position
  input  wire logic        in_tuser,   // [0] opcode
  input  wire logic        in_tlast,   // is_last
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,  // [15:0] match_position
  input  wire logic        out_tuser,  // [0] found
  output int               err_count,
  output int               pending_count
);

  localparam longint IDX_MAX     = (longint'(1) << TEXT_INDEX_BITS) - 1;
  localparam int     MAX_REPORTS = 10;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } search_result_t;

  logic [CHAR_W-1:0] pat_bytes [MAX_PATTERN];
  int                fallback  [MAX_PATTERN];
  int                pat_len;
  int                matched;
  longint            txt_idx;
  longint            srch_start;
  longint            first_hit;
  bit                hit_seen;
  bit                pat_closed;
  bit                in_text;
  search_result_t    expected_hits [$];
  int                n_reported;

  // Failure table of the stored pattern; entry 0 is the -1 sentinel.
  function automatic void build_fallback();
    int j;
    int t;
    j = 0;
    t = -1;
    if (pat_len == 0) return;
    fallback[0] = -1;
    while (j + 1 < pat_len) begin
      if (t < 0 || pat_bytes[j] == pat_bytes[t]) begin
        j++;
        t++;
        fallback[j] = t;
      end else begin
        t = fallback[t];
      end
    end
  endfunction

  // Advances the search by one accepted word and queues a result on the
  // last byte of a text.
  function automatic void search_word(input opcode_t op, input logic [CHAR_W-1:0] c,
                                      input logic last, input logic [POS_W-1:0] start);
    longint         cur;
    int             j;
    search_result_t r;
    if (op == OP_PATTERN) begin
      in_text = 1'b0;
      if (pat_closed) begin
        pat_len    = 0;
        pat_closed = 1'b0;
      end
      if (pat_len < MAX_PATTERN) begin
        pat_bytes[pat_len] = c;
        pat_len++;
      end
      if (last) begin
        build_fallback();
        pat_closed = 1'b1;
      end
      return;
    end
    // A text byte closes a pattern that is still open.
    if (!pat_closed) begin
      build_fallback();
      pat_closed = 1'b1;
    end
    if (!in_text) begin
      in_text    = 1'b1;
      srch_start = start;
      txt_idx    = 0;
      matched    = 0;
      hit_seen   = 1'b0;
      first_hit  = 0;
    end
    cur = txt_idx;
    if (txt_idx < IDX_MAX) txt_idx++;
    if (pat_len > 0 && !hit_seen && cur >= srch_start) begin
      j = matched;
      if (j >= pat_len) j = 0;
      while (j > 0 && c != pat_bytes[j]) j = fallback[j];
      if (c == pat_bytes[j]) j++;
      if (j == pat_len) begin
        hit_seen  = 1'b1;
        first_hit = (cur + 1 >= pat_len) ? cur + 1 - pat_len : 0;
        j         = 0;
      end
      matched = j;
    end
    if (last) begin
      in_text = 1'b0;
      if (pat_len == 0) begin
        r.found = (srch_start < txt_idx);
        r.pos   = r.found ? POS_W'(srch_start) : '0;
      end else begin
        r.found = hit_seen;
        r.pos   = hit_seen ? POS_W'(first_hit) : '0;
      end
      expected_hits.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    search_result_t want;
    if (!rst_n) begin
      pat_len    = 0;
      matched    = 0;
      txt_idx    = 0;
      srch_start = 0;
      first_hit  = 0;
      hit_seen   = 1'b0;
      pat_closed = 1'b0;
      in_text    = 1'b0;
      err_count  = 0;
      n_reported = 0;
      expected_hits.delete();
    end else begin
      if (in_tvalid && in_tready)
        search_word(opcode_t'(in_tuser), in_tdata[CHAR_W-1:0], in_tlast,
                    in_tdata[CHAR_W +: POS_W]);
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          err_count++;
          if (n_reported < MAX_REPORTS)
            $display("%0t: unexpected result word found=%0d pos=%0d",
                     $realtime, out_tuser, out_tdata);
          n_reported++;
        end else begin
          want = expected_hits.pop_front();
          if (out_tuser !== want.found || out_tdata !== want.pos) begin
            err_count++;
            if (n_reported < MAX_REPORTS)
              $display("%0t: result mismatch: found exp %0d got %0d, pos exp %0d got %0d",
                       $realtime, want.found, out_tuser, want.pos, out_tdata);
            n_reported++;
          end
        end
      end
    end
    pending_count = expected_hits.size();
  end

endmodule

### tb/kmp_substring_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmp_substring_search_tb
// Drives patterns and texts into the substring search block: a directed
// opening for the corner cases, then random pattern/text sessions under
// several idle and stall settings. A checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------

module kmp_substring_search_tb;
  import kmpss_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int RX_HOLD_CYCLES  = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [7:0] char_value, [23:8] start_position
  logic        in_tuser   = 1'b0; // [0] opcode
  logic        in_tlast   = 1'b0; // is_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] match_position
  logic        out_tuser;         // [0] found

  int err_count;
  int pending_count;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_len = 0;
  int words_sent = 0;
  int idle_cycles = 0;

  logic [7:0] pat_q [$];
  logic [7:0] txt_q [$];
  logic [7:0] sym [4];
  int         n_sym;

  always #5 clk = ~clk;

  kmp_substring_search u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  kmp_result_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .err_count     (err_count),
    .pending_count (pending_count)
  );

  // Result side: a requested hold-off takes priority over random stalls.
  always @(negedge clk) begin
    if (rx_hold_len > 0) begin
      out_tready = 1'b0;
      rx_hold_len = rx_hold_len - 1;
    end else begin
      out_tready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Ends the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one word, with random gaps before it, and returns once it is taken.
  task automatic send_word(input opcode_t op, input logic [7:0] c, input logic last,
                           input logic [15:0] start);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tlast  = last;
    in_tdata  = {start, c};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Stops offering and waits until every predicted result has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Fill the byte queues from a packed literal, first byte in the top bits.
  task automatic set_pattern(input logic [63:0] b, input int n);
    pat_q.delete();
    for (int i = 0; i < n; i++) pat_q.push_back(b[8*(n-1-i) +: 8]);
  endtask

  task automatic set_text(input logic [63:0] b, input int n);
    txt_q.delete();
    for (int i = 0; i < n; i++) txt_q.push_back(b[8*(n-1-i) +: 8]);
  endtask

  // The start field is ignored on pattern words, so it gets random values.
  task automatic send_pattern(input bit close);
    for (int i = 0; i < pat_q.size(); i++)
      send_word(OP_PATTERN, pat_q[i], close && (i == pat_q.size() - 1),
                16'($urandom_range(16'hFFFF)));
  endtask

  task automatic send_text(input logic [15:0] start, input bit close);
    for (int i = 0; i < txt_q.size(); i++)
      send_word(OP_TEXT, txt_q[i], close && (i == txt_q.size() - 1),
                (i == 0) ? start : 16'($urandom_range(16'hFFFF)));
  endtask

  // One pattern followed by a few texts over a small random alphabet, so that
  // matches and partial matches are common. Now and then the pattern is left
  // open, runs past the store, or a text is cut off by the next pattern.
  task automatic random_session();
    int len;
    int n_txt;
    int pos;
    int start;
    bit close;
    n_sym = $urandom_range(1, 4);
    for (int k = 0; k < 4; k++) sym[k] = 8'($urandom_range(255));
    pat_q.delete();
    len = ($urandom_range(9) == 0) ? $urandom_range(7, MAX_PATTERN_DEF + 6)
                                   : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) pat_q.push_back(sym[$urandom_range(n_sym - 1)]);
    send_pattern($urandom_range(9) != 0);
    n_txt = $urandom_range(1, 3);
    for (int t = 0; t < n_txt; t++) begin
      txt_q.delete();
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) txt_q.push_back(sym[$urandom_range(n_sym - 1)]);
      if ($urandom_range(1) == 1 && pat_q.size() <= len) begin
        pos = $urandom_range(len - pat_q.size());
        for (int i = 0; i < pat_q.size(); i++) txt_q[pos + i] = pat_q[i];
      end
      case ($urandom_range(9))
        0:       start = $urandom_range(16'hFFFF);
        1, 2:    start = 0;
        default: start = $urandom_range(len);
      endcase
      close = ($urandom_range(19) != 0);
      send_text(16'(start), close);
      // An open text is ended by the pattern of the next session.
      if (!close) break;
    end
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int hold);
    int goal;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    goal = words_sent + ITEMS_PER_PHASE;
    random_session();
    // The sender keeps going while the result side holds off, so the
    // output register fills and the block has to stall its input.
    rx_hold_len = hold;
    while (words_sent < goal) random_session();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Right after reset the pattern is empty: it matches at the start index
    // as long as that index lies inside the text.
    set_text(64'h4142, 2);
    send_text(16'd1, 1'b1);
    send_text(16'd2, 1'b1);
    set_text(64'hFF, 1);
    send_text(16'd0, 1'b1);

    // A pattern left open is closed by the first text byte.
    set_pattern(64'h6161, 2);
    send_pattern(1'b0);
    set_text(64'h61626161, 4);
    send_text(16'd0, 1'b1);

    // Extreme byte values and the largest start index.
    set_pattern(64'h00FF, 2);
    send_pattern(1'b1);
    set_text(64'hFF00FF00, 4);
    send_text(16'd0, 1'b1);
    set_text(64'h00FF, 2);
    send_text(16'hFFFF, 1'b1);

    // A text cut off by a new pattern gives no result; the next text needs
    // a fallback through the table, and its byte after the match is only
    // counted.
    send_text(16'd0, 1'b0);
    set_pattern(64'h616162, 3);
    send_pattern(1'b1);
    set_text(64'h6161616261, 5);
    send_text(16'd0, 1'b1);
    wait_drained();

    run_phase(0, 0, RX_HOLD_CYCLES);
    run_phase(81, 0, 0);
    run_phase(0, 81, 0);
    run_phase(22, 22, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
